// ===== src/huf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_pkg
// Shared constants, action codes and index folding for the tree-walk decoder.
// ----------------------------------------------------------------------------
package huf_pkg;

  // Default sizes
  localparam int unsigned HUF_NODE_COUNT   = 512;
  localparam int unsigned HUF_SYMBOL_WIDTH = 8;

  // Fixed field widths
  localparam int unsigned IN_IDX_W    = 9;
  localparam int unsigned SYM_OUT_W   = 8;
  localparam int unsigned COUNT_W     = 24;
  localparam int unsigned IDX_FOLD_W  = 13;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Action codes carried in tuser
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_BIT    = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  // Fold a 9-bit node index into the node range by conditional subtraction
  // of shifted multiples of the node count (one compare and subtract a step).
  function automatic logic [IDX_FOLD_W-1:0] wrap_node(input logic [IN_IDX_W-1:0] v,
                                                      input int unsigned n);
    logic [IDX_FOLD_W-1:0] r;
    r = IDX_FOLD_W'(v);
    for (int k = 7; k >= 0; k--) begin
      if (32'(r) >= (n << k)) begin
        r = r - IDX_FOLD_W'(n << k);
      end
    end
    return r;
  endfunction

endpackage

// ===== src/huf_node_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_node_mem
// Node memory: one write port, two registered read ports, write forwarding.
// ----------------------------------------------------------------------------
module huf_node_mem #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = 9,
  parameter int unsigned DATA_W = 27
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;
  logic [DATA_W-1:0] wdata_r;
  logic              hit_a_r;
  logic              hit_b_r;

  // Write and read; reads return the old word on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r  <= mem_r[rd_addr_a];
    rd_b_r  <= mem_r[rd_addr_b];
    wdata_r <= wr_data;
  end

  // Note collisions so the fresh word can be forwarded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_a_r <= 1'b0;
      hit_b_r <= 1'b0;
    end else begin
      hit_a_r <= wr_en && (wr_addr == rd_addr_a);
      hit_b_r <= wr_en && (wr_addr == rd_addr_b);
    end
  end

  // Forward the just-written word over stale read data
  assign rd_data_a = hit_a_r ? wdata_r : rd_a_r;
  assign rd_data_b = hit_b_r ? wdata_r : rd_b_r;

endmodule

// ===== src/huf_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_walker
// Walk control: position, root, symbol count, node loads and result register.
// ----------------------------------------------------------------------------
module huf_walker #(
  parameter int unsigned NODE_COUNT   = 512,
  parameter int unsigned SYMBOL_WIDTH = 8,
  parameter int unsigned IDX_W        = 9,
  parameter int unsigned NODE_W       = 27
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // item side
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic [8:0]              in_node_addr,
  input  logic [8:0]              in_left_index,
  input  logic [8:0]              in_right_index,
  input  logic                    in_is_leaf,
  input  logic [7:0]              in_leaf_symbol,
  input  logic                    in_code_bit,
  // root register write
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [8:0]              cfg_root,
  // result side
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_symbol,
  output logic [23:0]             out_count,
  // node memory
  output logic                    mem_wr_en,
  output logic [IDX_W-1:0]        mem_wr_addr,
  output logic [NODE_W-1:0]       mem_wr_data,
  output logic [IDX_W-1:0]        mem_rd_addr_a,
  output logic [IDX_W-1:0]        mem_rd_addr_b,
  input  logic [NODE_W-1:0]       mem_rd_data_a,
  input  logic [NODE_W-1:0]       mem_rd_data_b
);

  import huf_pkg::*;

  localparam int unsigned LEAF_B  = SYMBOL_WIDTH;
  localparam int unsigned RIGHT_L = SYMBOL_WIDTH + 1;
  localparam int unsigned LEFT_L  = SYMBOL_WIDTH + 1 + IDX_W;

  logic [IDX_W-1:0]        root_r, root_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic [COUNT_W-1:0]      count_r, count_nxt, count_inc;
  logic                    out_valid_r;
  logic [SYM_OUT_W-1:0]    out_symbol_r;
  logic [COUNT_W-1:0]      out_count_r;

  logic                    in_acc;
  logic                    cfg_acc;
  logic                    emit;
  logic [IDX_FOLD_W-1:0]   cfg_fold, addr_fold, left_fold, right_fold;
  logic [NODE_W-1:0]       step_node;
  logic [IDX_W-1:0]        step_pos;
  logic [IDX_W-1:0]        walk_pos;
  logic                    cur_leaf;

  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid;

  // Fold incoming indices into the node range
  assign cfg_fold   = wrap_node(cfg_root, NODE_COUNT);
  assign addr_fold  = wrap_node(in_node_addr, NODE_COUNT);
  assign left_fold  = wrap_node(in_left_index, NODE_COUNT);
  assign right_fold = wrap_node(in_right_index, NODE_COUNT);

  // Node load word: left, right, leaf flag, symbol
  assign mem_wr_en   = in_acc && (in_action == ACT_LOAD);
  assign mem_wr_addr = addr_fold[IDX_W-1:0];
  assign mem_wr_data = {left_fold[IDX_W-1:0], right_fold[IDX_W-1:0], in_is_leaf,
                        in_leaf_symbol[SYMBOL_WIDTH-1:0]};

  // One tree step: restart at the root after a leaf, then follow the bit
  assign cur_leaf  = mem_rd_data_a[LEAF_B];
  assign step_node = cur_leaf ? mem_rd_data_b : mem_rd_data_a;
  assign step_pos  = cur_leaf ? root_r : pos_r;
  assign walk_pos  = step_node[LEAF_B] ? step_pos :
                     (in_code_bit ? step_node[RIGHT_L +: IDX_W]
                                  : step_node[LEFT_L +: IDX_W]);

  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(1);

  // Next walker state
  always_comb begin
    pos_nxt   = pos_r;
    root_nxt  = root_r;
    count_nxt = count_r;
    emit      = 1'b0;
    if (in_acc) begin
      unique case (in_action)
        ACT_BIT: begin
          pos_nxt = walk_pos;
          if (cur_leaf) begin
            emit      = 1'b1;
            count_nxt = count_inc;
          end
        end
        ACT_FINISH: begin
          emit      = 1'b1;
          count_nxt = '0;
          pos_nxt   = root_r;
        end
        default: begin
        end
      endcase
    end
    if (cfg_acc) begin
      root_nxt = cfg_fold[IDX_W-1:0];
      pos_nxt  = cfg_fold[IDX_W-1:0];
    end
  end

  // Fetch the next node and the root every cycle
  assign mem_rd_addr_a = pos_nxt;
  assign mem_rd_addr_b = root_nxt;

  // Hold walker state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= '0;
      pos_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      root_r  <= root_nxt;
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the result word
  always_ff @(posedge clk) begin
    if (emit) begin
      out_symbol_r <= SYM_OUT_W'(mem_rd_data_a[SYMBOL_WIDTH-1:0]);
      out_count_r  <= count_inc;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_count  = out_count_r;

`ifndef ASSERT_OFF
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r != '0))
    else $error("result carries a zero symbol count");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == ACT_FINISH)) |=> (count_r == '0))
    else $error("count not cleared after finish");

  a_cfg_moves_walker: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (pos_r == root_r))
    else $error("walker not at root after root write");

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready))
    else $error("input stalled with free result register");
`endif

endmodule

// ===== src/huffman_tree_walk_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Huffman decoder walking a code tree stored in an on-chip node memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per item. in_tuser selects load node, decode one code
//           bit, or finish message; in_tdata carries the node and bit fields.
//   out_* : one word per emitted symbol with the running symbol count.
//   cfg_* : writes the root node index; the walker moves to the new root.
//           Write it only while no item is in flight.
// Throughput: one item per cycle while no result waits on out_tready.
// The node memory is read every cycle at the next walk position; the child
// chosen from the word just read is the next read address and sets the rate.
// Latency: a symbol is presented on out_* the cycle after its item is taken.
// Reset: root and walker at node 0, count cleared, result register empty.
// The node memory is not cleared; nodes must be loaded before they are walked.
// Stall: while a result waits on out_tready the next item is held off;
// in_tready rises again in the cycle the result is taken.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder #(
  parameter int unsigned NODE_COUNT   = huf_pkg::HUF_NODE_COUNT,
  parameter int unsigned SYMBOL_WIDTH = huf_pkg::HUF_SYMBOL_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [8:0] node_addr, [17:9] left_index, [26:18] right_index, [27] is_leaf,
  // [35:28] leaf_symbol, [36] code_bit, [39:37] zero
  input  logic [39:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  // [8:0] root_node
  input  logic [8:0]  cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] symbol, [31:8] symbol_count
  output logic [31:0] out_tdata
);

  import huf_pkg::*;

  localparam int unsigned IDX_W  = $clog2(NODE_COUNT);
  localparam int unsigned NODE_W = 2 * IDX_W + 1 + SYMBOL_WIDTH;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [NODE_W-1:0]   wr_data;
  logic [IDX_W-1:0]    rd_addr_a, rd_addr_b;
  logic [NODE_W-1:0]   rd_data_a, rd_data_b;
  logic [SYM_OUT_W-1:0] sym;
  logic [COUNT_W-1:0]  cnt;

  huf_node_mem #(
    .DEPTH  (NODE_COUNT),
    .ADDR_W (IDX_W),
    .DATA_W (NODE_W)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  huf_walker #(
    .NODE_COUNT   (NODE_COUNT),
    .SYMBOL_WIDTH (SYMBOL_WIDTH),
    .IDX_W        (IDX_W),
    .NODE_W       (NODE_W)
  ) u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_action      (in_tuser),
    .in_node_addr   (in_tdata[8:0]),
    .in_left_index  (in_tdata[17:9]),
    .in_right_index (in_tdata[26:18]),
    .in_is_leaf     (in_tdata[27]),
    .in_leaf_symbol (in_tdata[35:28]),
    .in_code_bit    (in_tdata[36]),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_root       (cfg_data),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_symbol     (sym),
    .out_count      (cnt),
    .mem_wr_en      (wr_en),
    .mem_wr_addr    (wr_addr),
    .mem_wr_data    (wr_data),
    .mem_rd_addr_a  (rd_addr_a),
    .mem_rd_addr_b  (rd_addr_b),
    .mem_rd_data_a  (rd_data_a),
    .mem_rd_data_b  (rd_data_b)
  );

  // Pack the result word
  assign out_tdata = {cnt, sym};

endmodule
